FILE: hw/rtl/aed_pkg.sv
package aed_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEFF_BITS  = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int LEVEL_BITS  = 25;
    localparam int MODE_BITS   = 2;
    localparam int INDEX_BITS  = 2;

    // Shared shift-add multiplier: a signed multiplicand, an unsigned
    // multiplier consumed one bit per cycle.
    localparam int MUL_A_BITS  = 26;
    localparam int MUL_B_BITS  = 24;
    localparam int MUL_CNT_BITS = 5;

    // log2 result in Q.16: six integer bits with sign, 16 fraction bits.
    localparam int LOG_FRAC_BITS = 16;
    localparam int LOG_BITS      = 22;
    localparam int LOG_M_BITS    = 31;

    localparam logic [MUL_B_BITS-1:0] DB_K    = MUL_B_BITS'(394566);
    localparam logic [LEVEL_BITS-1:0] DB_ZERO = LEVEL_BITS'(-24576);

    localparam logic [INDEX_BITS-1:0] REG_ATTACK  = 2'd0;
    localparam logic [INDEX_BITS-1:0] REG_RELEASE = 2'd1;
    localparam logic [INDEX_BITS-1:0] REG_MODE    = 2'd2;
    localparam logic [INDEX_BITS-1:0] REG_DB      = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_PEAK = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MS   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_RMS  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQUARE,
        ST_SETUP,
        ST_SMOOTH,
        ST_SQRT,
        ST_FINISH,
        ST_LOG,
        ST_DB,
        ST_OUT
    } det_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_FRAC
    } log_state_t;

endpackage

FILE: hw/rtl/aed_sermul.sv
module aed_sermul
    import aed_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [MUL_A_BITS-1:0] a,
    input  logic        [MUL_B_BITS-1:0] b,
    output logic                         done,
    output logic signed [MUL_A_BITS-1:0] prod,
    output logic                         prod_lsb
);

    logic signed [MUL_A_BITS-1:0] a_reg;
    logic        [MUL_B_BITS-1:0] b_reg;
    logic signed [MUL_A_BITS-1:0] acc_reg;
    logic                         lsb_reg;
    logic      [MUL_CNT_BITS-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic signed [MUL_A_BITS:0]   sum;

    // Each step adds the multiplicand when the current multiplier bit is set
    // and halves the sum, so after all steps acc holds floor(a*b / 2^24).
    always_comb
    begin
        sum = {acc_reg[MUL_A_BITS-1], acc_reg}
            + (b_reg[0] ? {a_reg[MUL_A_BITS-1], a_reg} : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_BITS'(MUL_B_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            lsb_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            b_reg   <= b_reg >> 1;
            acc_reg <= sum[MUL_A_BITS:1];
            lsb_reg <= sum[0];
        end
    end

    assign done     = done_reg;
    assign prod     = acc_reg;
    assign prod_lsb = lsb_reg;

endmodule

FILE: hw/rtl/aed_log2.sv
module aed_log2
    import aed_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [SAMPLE_BITS-1:0]     lv,
    output logic                       done,
    output logic signed [LOG_BITS-1:0] log_q
);

    localparam int SHIFT_BITS = 5;
    localparam int INT_BITS   = LOG_BITS - LOG_FRAC_BITS;
    localparam int CNT_BITS   = 4;

    log_state_t                  state_reg, state_next;
    logic [SAMPLE_BITS-1:0]      n_reg, n_next;
    logic [SHIFT_BITS-1:0]       s_reg, s_next;
    logic [LOG_M_BITS-1:0]       m_reg, m_next;
    logic [LOG_FRAC_BITS-1:0]    frac_reg, frac_next;
    logic [CNT_BITS-1:0]         cnt_reg, cnt_next;
    logic                        done_reg, done_next;
    logic [2*LOG_M_BITS-1:0]     sq;
    logic [LOG_M_BITS:0]         q;
    logic [INT_BITS-1:0]         int_part;

    // The mantissa is held as Q1.30; each squaring yields one fraction bit.
    always_comb
    begin
        sq = m_reg * m_reg;
        q  = sq[2*LOG_M_BITS-1:LOG_M_BITS-1];
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        s_next     = s_reg;
        m_next     = m_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            LG_IDLE:
            begin
                if (start)
                begin
                    n_next     = lv;
                    s_next     = '0;
                    state_next = LG_NORM;
                end
            end
            LG_NORM:
            begin
                if (n_reg[SAMPLE_BITS-1])
                begin
                    m_next     = {n_reg, (LOG_M_BITS - SAMPLE_BITS)'(0)};
                    frac_next  = '0;
                    cnt_next   = '0;
                    state_next = LG_FRAC;
                end
                else
                begin
                    n_next = n_reg << 1;
                    s_next = s_reg + 1'b1;
                end
            end
            LG_FRAC:
            begin
                frac_next = {frac_reg[LOG_FRAC_BITS-2:0], q[LOG_M_BITS]};
                m_next    = q[LOG_M_BITS] ? q[LOG_M_BITS:1] : q[LOG_M_BITS-1:0];
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(LOG_FRAC_BITS - 1))
                begin
                    done_next  = 1'b1;
                    state_next = LG_IDLE;
                end
            end
            default:
            begin
                state_next = LG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        s_reg    <= s_next;
        m_reg    <= m_next;
        frac_reg <= frac_next;
        cnt_reg  <= cnt_next;
    end

    // The integer part is the leading-one position minus the fraction width,
    // which is the negated normalizing shift.
    assign int_part = INT_BITS'(0) - {{(INT_BITS - SHIFT_BITS){1'b0}}, s_reg};
    assign log_q    = {int_part, frac_reg};
    assign done     = done_reg;

endmodule

FILE: hw/rtl/audio_envelope_detector_core.sv
// In peak mode with linear output an accepted word takes the shortest path to its result
// word; RMS mode with dB output takes the longest (square, smoother, 24-step square
// root, log normalize and 16 squarings, then the dB multiply).
// One word is in flight at a time, so a new word is taken only once the last has reached
// the output register, also while that result waits.
// Reset clears the envelope, all configuration registers and the output valid flag.
module audio_envelope_detector_core
    import aed_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [23:0]            s_tdata,   // [23:0] sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // [24:0] level
    input  logic                   cfg_we,
    input  logic [INDEX_BITS-1:0]  cfg_index,
    input  logic [COEFF_BITS-1:0]  cfg_data
);

    localparam int RAD_BITS  = 2 * SAMPLE_BITS;
    localparam int REM_BITS  = SAMPLE_BITS + 2;
    localparam int CNT_BITS  = 5;

    det_state_t                     state_reg, state_next;
    logic [COEFF_BITS-1:0]          attack_reg;
    logic [COEFF_BITS-1:0]          release_reg;
    logic [MODE_BITS-1:0]           mode_reg;
    logic                           db_reg;
    logic [SAMPLE_BITS-1:0]         env_reg, env_next;
    logic [SAMPLE_BITS-1:0]         x_reg, x_next;
    logic [SAMPLE_BITS-1:0]         lv_reg, lv_next;
    logic [RAD_BITS-1:0]            rad_reg, rad_next;
    logic [REM_BITS-1:0]            rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0]         root_reg, root_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic [LEVEL_BITS-1:0]          res_reg, res_next;
    logic [LEVEL_BITS-1:0]          level_reg, level_next;
    logic                           valid_reg, valid_next;

    logic                           mul_start;
    logic signed [MUL_A_BITS-1:0]   mul_a;
    logic        [MUL_B_BITS-1:0]   mul_b;
    logic                           mul_done;
    logic signed [MUL_A_BITS-1:0]   mul_prod;
    logic                           mul_lsb;
    logic                           log_start;
    logic                           log_done;
    logic signed [LOG_BITS-1:0]     log_q;

    logic [SAMPLE_BITS-1:0]         mag;
    logic                           square_mode;
    logic signed [SAMPLE_BITS:0]    diff;
    logic [COEFF_BITS-1:0]          coeff;
    logic [MUL_A_BITS-1:0]          env_sum;
    logic [REM_BITS+1:0]            rem_sh;
    logic [REM_BITS+1:0]            trial;
    logic                           take;

    aed_sermul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mul_start),
        .a        (mul_a),
        .b        (mul_b),
        .done     (mul_done),
        .prod     (mul_prod),
        .prod_lsb (mul_lsb)
    );

    aed_log2 u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .start (log_start),
        .lv    (lv_reg),
        .done  (log_done),
        .log_q (log_q)
    );

    always_comb
    begin
        mag         = s_tdata[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - s_tdata)
                                             : s_tdata;
        square_mode = (mode_reg == MODE_MS) || (mode_reg == MODE_RMS);
        diff        = $signed({1'b0, env_reg}) - $signed({1'b0, x_reg});
        coeff       = (x_reg > env_reg) ? attack_reg : release_reg;
        env_sum     = mul_prod + MUL_A_BITS'(x_reg);
        // One root bit per cycle from two radicand bits.
        rem_sh      = {rem_reg, rad_reg[RAD_BITS-1:RAD_BITS-2]};
        trial       = {2'b00, root_reg, 2'b01};
        take        = (rem_sh >= trial);
    end

    always_comb
    begin
        state_next = state_reg;
        env_next   = env_reg;
        x_next     = x_reg;
        lv_next    = lv_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        level_next = level_reg;
        valid_next = valid_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        log_start  = 1'b0;
        s_tready   = 1'b0;

        if (valid_reg && m_tready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    x_next     = mag;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                if (square_mode)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_BITS'(x_reg);
                    mul_b      = x_reg;
                    state_next = ST_SQUARE;
                end
                else
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SQUARE:
            begin
                if (mul_done)
                begin
                    x_next     = {mul_prod[SAMPLE_BITS-2:0], mul_lsb};
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                mul_start  = 1'b1;
                mul_a      = MUL_A_BITS'(diff);
                mul_b      = {coeff, (MUL_B_BITS - COEFF_BITS)'(0)};
                state_next = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                if (mul_done)
                begin
                    env_next = env_sum[SAMPLE_BITS-1:0];
                    lv_next  = env_sum[SAMPLE_BITS-1:0];
                    if (mode_reg == MODE_RMS)
                    begin
                        rad_next   = {1'b0, env_sum[SAMPLE_BITS-1:0],
                                      (RAD_BITS - SAMPLE_BITS - 1)'(0)};
                        rem_next   = '0;
                        root_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SQRT:
            begin
                rad_next = rad_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (take)
                begin
                    rem_next  = REM_BITS'(rem_sh - trial);
                    root_next = {root_reg[SAMPLE_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh[REM_BITS-1:0];
                    root_next = {root_reg[SAMPLE_BITS-2:0], 1'b0};
                end
                if (cnt_reg == CNT_BITS'(SAMPLE_BITS - 1))
                begin
                    lv_next    = root_next;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!db_reg)
                begin
                    res_next   = LEVEL_BITS'(lv_reg);
                    state_next = ST_OUT;
                end
                else if (lv_reg == '0)
                begin
                    res_next   = DB_ZERO;
                    state_next = ST_OUT;
                end
                else
                begin
                    log_start  = 1'b1;
                    state_next = ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (log_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MUL_A_BITS'(log_q);
                    mul_b      = DB_K;
                    state_next = ST_DB;
                end
            end
            ST_DB:
            begin
                if (mul_done)
                begin
                    res_next   = mul_prod[LEVEL_BITS-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!valid_reg || m_tready)
                begin
                    level_next = res_reg;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            env_reg     <= '0;
            valid_reg   <= 1'b0;
            attack_reg  <= '0;
            release_reg <= '0;
            mode_reg    <= MODE_PEAK;
            db_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            env_reg   <= env_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_reg  <= cfg_data;
                    REG_RELEASE: release_reg <= cfg_data;
                    REG_MODE:    mode_reg    <= cfg_data[MODE_BITS-1:0];
                    REG_DB:      db_reg      <= cfg_data[0];
                    default:     db_reg      <= db_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lv_reg    <= lv_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        level_reg <= level_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(32 - LEVEL_BITS)'(0), level_reg};

endmodule

FILE: tb/aed_level_check.sv
`timescale 1ns / 100ps

module aed_level_check
    import aed_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [23:0] sample
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [24:0] level
    input  logic                  cfg_we,
    input  logic [INDEX_BITS-1:0] cfg_index,
    input  logic [COEFF_BITS-1:0] cfg_data,
    output int                    error_count,
    output int                    levels_pending
);

    logic [SAMPLE_BITS-1:0] envelope_q;
    logic [COEFF_BITS-1:0]  attack_q;
    logic [COEFF_BITS-1:0]  release_q;
    logic [MODE_BITS-1:0]   mode_q;
    logic                   db_q;

    logic [31:0] expected_levels[$];
    logic [31:0] oldest_level;
    int          errors = 0;
    int          pending_count = 0;

    assign error_count    = errors;
    assign levels_pending = pending_count;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > v)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (v >= root + probe)
            begin
                v    = v - (root + probe);
                root = (root >> 1) + probe;
            end
            else
            begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Leading one gives the integer part; the fraction comes from repeated
    // squaring of the mantissa held as Q1.30.
    function automatic longint log2_fixed(input longint unsigned lv);
        int              e;
        longint unsigned m;
        longint          frac;
        e    = 63;
        frac = 0;
        while (e > 0 && ((lv >> e) & 64'd1) == 0)
            e--;
        if (e <= 30)
            m = lv << (30 - e);
        else
            m = lv >> (e - 30);
        for (int i = 0; i < LOG_FRAC_BITS; i++)
        begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return longint'(e - FRAC_BITS) * 65536 + frac;
    endfunction

    function automatic logic [LEVEL_BITS-1:0] predict_level(input logic [SAMPLE_BITS-1:0] smp);
        longint unsigned mag;
        longint unsigned lv;
        longint          diff;
        longint          prod;
        longint          nv;
        longint          level;
        logic [COEFF_BITS-1:0] k;
        mag = smp[SAMPLE_BITS-1] ? (64'd1 << SAMPLE_BITS) - {40'd0, smp} : {40'd0, smp};
        if (mode_q == MODE_MS || mode_q == MODE_RMS)
            mag = (mag * mag) >> FRAC_BITS;
        k    = (mag > {40'd0, envelope_q}) ? attack_q : release_q;
        diff = longint'({40'd0, envelope_q}) - longint'(mag);
        prod = longint'({48'd0, k}) * diff;
        nv   = (prod >>> COEFF_BITS) + longint'(mag);
        if (nv < 0)
            nv = 0;
        if (nv > longint'((64'd1 << SAMPLE_BITS) - 1))
            nv = longint'((64'd1 << SAMPLE_BITS) - 1);
        envelope_q = nv[SAMPLE_BITS-1:0];
        lv = {40'd0, envelope_q};
        if (mode_q == MODE_RMS)
            lv = int_sqrt(lv << FRAC_BITS);
        if (!db_q)
            level = longint'(lv);
        else if (lv == 0)
            level = longint'($signed(DB_ZERO));
        else
            level = (log2_fixed(lv) * longint'({40'd0, DB_K})) >>> 24;
        return level[LEVEL_BITS-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            envelope_q = '0;
            attack_q   = '0;
            release_q  = '0;
            mode_q     = MODE_PEAK;
            db_q       = 1'b0;
            expected_levels.delete();
            pending_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_q  = cfg_data;
                    REG_RELEASE: release_q = cfg_data;
                    REG_MODE:    mode_q    = cfg_data[MODE_BITS-1:0];
                    REG_DB:      db_q      = cfg_data[0];
                    default:     ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_levels.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected level word, expected none, actual %h",
                             $time, m_tdata);
                end
                else
                begin
                    oldest_level = expected_levels.pop_front();
                    if (m_tdata !== oldest_level)
                    begin
                        errors++;
                        $display("%0t: level mismatch, expected %h, actual %h",
                                 $time, oldest_level, m_tdata);
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_levels.push_back({{(32 - LEVEL_BITS){1'b0}}, predict_level(s_tdata)});
            pending_count <= expected_levels.size();
        end
    end

endmodule

FILE: tb/tb_audio_envelope_detector_core.sv
`timescale 1ns / 100ps

module tb_audio_envelope_detector_core;
    import aed_pkg::*;

    localparam int RANDOM_PHASES   = 12;
    localparam int WORDS_PER_PHASE = 170;
    localparam int CYCLE_LIMIT     = 6000000;
    localparam int TAIL_CYCLES     = 200;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [23:0]           s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [INDEX_BITS-1:0] cfg_index = REG_ATTACK;
    logic [COEFF_BITS-1:0] cfg_data  = '0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [31:0]           m_tdata;
    int                    error_count;
    int                    levels_pending;
    bit                    no_gaps = 1'b0;

    audio_envelope_detector_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aed_level_check level_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .error_count    (error_count),
        .levels_pending (levels_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // The receiver mixes short stalls, long stalls and long ready stretches.
    initial
    begin
        int roll;
        int hold;
        forever
        begin
            @(posedge clk);
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                m_tready <= 1'b1;
            end
            else if (roll < 90)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(1, 4);
                repeat (hold - 1) @(posedge clk);
            end
            else if (roll < 95)
            begin
                m_tready <= 1'b0;
                hold = $urandom_range(20, 150);
                repeat (hold - 1) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                hold = $urandom_range(100, 400);
                repeat (hold - 1) @(posedge clk);
            end
        end
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_gaps || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 95)
            return $urandom_range(4, 25);
        return $urandom_range(30, 200);
    endfunction

    function automatic logic [23:0] random_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            return 24'($urandom);
        if (roll < 55)
            return 24'(int'($urandom_range(0, 512)) - 256);
        if (roll < 65)
            return 24'h000000;
        if (roll < 75)
        begin
            case ($urandom_range(0, 3))
                0:       return 24'h7FFFFF;
                1:       return 24'h800000;
                2:       return 24'hFFFFFF;
                default: return 24'h000001;
            endcase
        end
        return 24'($signed(24'($urandom)) >>> $urandom_range(1, 20));
    endfunction

    function automatic logic [COEFF_BITS-1:0] random_coeff();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return COEFF_BITS'(65535 - $urandom_range(0, 2000));
            default: return COEFF_BITS'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [INDEX_BITS-1:0] idx,
                             input logic [COEFF_BITS-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Valid stays high between back-to-back words; it is lowered only for a gap or while waiting for idle.
    task automatic send_word(input logic [23:0] smp);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (levels_pending != 0)
            @(posedge clk);
    endtask

    task automatic apply_settings(input int phase);
        logic [COEFF_BITS-1:0] attack;
        logic [COEFF_BITS-1:0] release_k;
        attack    = random_coeff();
        release_k = random_coeff();
        if (phase == 0)
        begin
            attack    = '0;
            release_k = '0;
        end
        else if (phase == 1)
        begin
            attack    = '1;
            release_k = '1;
        end
        write_reg(REG_ATTACK, attack);
        write_reg(REG_RELEASE, release_k);
        write_reg(REG_MODE, {(COEFF_BITS - MODE_BITS)'($urandom),
                             MODE_BITS'($urandom_range(0, 3))});
        write_reg(REG_DB, COEFF_BITS'($urandom));
    endtask

    initial
    begin
        int sent;
        int run;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: peak, coefficients at zero, linear output.
        send_word(24'h000000);
        send_word(24'h7FFFFF);
        send_word(24'h800000);
        send_word(24'hFFFFFF);
        send_word(24'h000001);
        send_word(24'h555555);
        send_word(24'hAAAAAA);
        wait_idle();

        // Mode three behaves as peak; zero level gives the dB floor.
        write_reg(REG_MODE, COEFF_BITS'(3));
        write_reg(REG_DB, COEFF_BITS'(1));
        send_word(24'h000000);
        send_word(24'h800000);
        send_word(24'h000001);
        send_word(24'h7FFFFF);
        wait_idle();

        // Oversized mode value keeps only its low bits (mean square).
        write_reg(REG_MODE, 16'hFFFD);
        write_reg(REG_DB, 16'hFFFE);
        write_reg(REG_ATTACK, 16'hFFFF);
        write_reg(REG_RELEASE, 16'h0000);
        send_word(24'h800000);
        send_word(24'h400000);
        send_word(24'h000000);
        wait_idle();

        write_reg(REG_MODE, {14'd0, MODE_RMS});
        write_reg(REG_DB, 16'h0001);
        write_reg(REG_ATTACK, 16'h0000);
        write_reg(REG_RELEASE, 16'hFFFF);
        send_word(24'h800000);
        send_word(24'h123456);
        send_word(24'h000000);
        send_word(24'hFFF000);
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            apply_settings(phase);
            no_gaps = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    run = $urandom_range(10, 40);
                    repeat (run) send_word(24'h000000);
                    sent += run;
                end
                else
                begin
                    send_word(random_sample());
                    sent++;
                end
                if ($urandom_range(0, 99) == 0)
                    wait_idle();
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && levels_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
